// File: sv/indexed_linked_list_engine_top_defines.svh
// Assertion macros used by the datapath of the indexed linked list engine.
`ifndef INDEXED_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
`define INDEXED_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ILLE_ASSERT_IMP(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ille assertion failed");
`define ILLE_ASSERT_NXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ille assertion failed");
`else
`define ILLE_ASSERT_IMP(name, clk, rst, pre, post)
`define ILLE_ASSERT_NXT(name, clk, rst, pre, post)
`endif
`endif

// File: sv/ille_pkg.sv
// Types, codes and control word layout of the indexed linked list engine.
package ille_pkg;

  localparam int UPC_BITS  = 5;
  localparam int POS_BITS  = 9;
  localparam int DATA_BITS = 32;
  localparam int LEN_BITS  = 9;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [UPC_BITS-1:0] upc_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SET_RANGE,
    OP_SET_FULL,
    OP_WALK_POS,
    OP_WALK_PRED,
    OP_HOP,
    OP_RD_VALUE,
    OP_TAKE_VALUE,
    OP_POP_ADDR,
    OP_POP,
    OP_WR_VALUE,
    OP_LINK_NS_Q,
    OP_LINK_CUR_NS,
    OP_LINK_NS_FIRST,
    OP_RD_VICTIM,
    OP_UNLINK,
    OP_DEL_HEAD,
    OP_PUSH,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_OUT_BUSY,
    COND_CMD_READ,
    COND_CMD_INSERT,
    COND_CMD_DELETE,
    COND_NOT_RANGE,
    COND_NOT_INS_RANGE,
    COND_FULL,
    COND_LP_ZERO,
    COND_LP_ONE,
    COND_K_NOT_ONE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  jump;
  } ctrl_t;

  typedef struct packed {
    logic is_read;
    logic is_insert;
    logic is_delete;
    logic in_range;
    logic ins_range;
    logic full;
    logic lp_zero;
    logic lp_one;
    logic k_one;
  } flags_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_value;
    logic [1:0]           status;
    logic [LEN_BITS-1:0]  list_length;
  } result_t;

endpackage

// File: sv/ille_channels.sv
// Command and response channel interfaces of the indexed linked list engine.
interface ille_cmd_if
  import ille_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic signed [POS_BITS-1:0]  position;
  logic signed [DATA_BITS-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink (input valid, command, position, value, output ready);
endinterface

interface ille_rsp_if
  import ille_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] read_value;
  logic [1:0]                  status;
  logic [LEN_BITS-1:0]         list_length;

  modport source (output valid, read_value, status, list_length, input ready);
  modport sink (input valid, read_value, status, list_length, output ready);
endinterface

// File: sv/ille_sequencer.sv
// Microprogram store, step counter and jump logic of the list engine.
module ille_sequencer
  import ille_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  logic   out_busy,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  localparam upc_t A_IDLE     = upc_t'(0);
  localparam upc_t A_BAD      = upc_t'(4);
  localparam upc_t A_RD       = upc_t'(5);
  localparam upc_t A_RD_LOOP  = upc_t'(7);
  localparam upc_t A_RD_VAL   = upc_t'(8);
  localparam upc_t A_INS      = upc_t'(10);
  localparam upc_t A_INS_LOOP = upc_t'(16);
  localparam upc_t A_INS_LINK = upc_t'(17);
  localparam upc_t A_INS_HEAD = upc_t'(19);
  localparam upc_t A_FULL     = upc_t'(20);
  localparam upc_t A_DEL      = upc_t'(21);
  localparam upc_t A_DEL_LOOP = upc_t'(24);
  localparam upc_t A_DEL_VIC  = upc_t'(25);
  localparam upc_t A_DEL_HEAD = upc_t'(27);
  localparam upc_t A_DEL_PUSH = upc_t'(29);
  localparam upc_t A_EMIT     = upc_t'(31);

  upc_t upc;
  upc_t upc_next;
  logic taken;

  function automatic ctrl_t word(op_t o, cond_t c, upc_t j);
    ctrl_t w;
    w.op   = o;
    w.cond = c;
    w.jump = j;
    return w;
  endfunction

  // The emit word sits at the top address, so its fall-through wraps to idle.
  always_comb begin
    case (upc)
      5'd0:    ctrl = word(OP_ACCEPT,        COND_NO_INPUT,      A_IDLE);
      5'd1:    ctrl = word(OP_NONE,          COND_CMD_READ,      A_RD);
      5'd2:    ctrl = word(OP_NONE,          COND_CMD_INSERT,    A_INS);
      5'd3:    ctrl = word(OP_NONE,          COND_CMD_DELETE,    A_DEL);
      5'd4:    ctrl = word(OP_SET_RANGE,     COND_ALWAYS,        A_EMIT);
      5'd5:    ctrl = word(OP_NONE,          COND_NOT_RANGE,     A_BAD);
      5'd6:    ctrl = word(OP_WALK_POS,      COND_LP_ZERO,       A_RD_VAL);
      5'd7:    ctrl = word(OP_HOP,           COND_K_NOT_ONE,     A_RD_LOOP);
      5'd8:    ctrl = word(OP_RD_VALUE,      COND_NEVER,         A_IDLE);
      5'd9:    ctrl = word(OP_TAKE_VALUE,    COND_ALWAYS,        A_EMIT);
      5'd10:   ctrl = word(OP_NONE,          COND_NOT_INS_RANGE, A_BAD);
      5'd11:   ctrl = word(OP_NONE,          COND_FULL,          A_FULL);
      5'd12:   ctrl = word(OP_POP_ADDR,      COND_NEVER,         A_IDLE);
      5'd13:   ctrl = word(OP_POP,           COND_NEVER,         A_IDLE);
      5'd14:   ctrl = word(OP_WR_VALUE,      COND_LP_ZERO,       A_INS_HEAD);
      5'd15:   ctrl = word(OP_WALK_PRED,     COND_LP_ONE,        A_INS_LINK);
      5'd16:   ctrl = word(OP_HOP,           COND_K_NOT_ONE,     A_INS_LOOP);
      5'd17:   ctrl = word(OP_LINK_NS_Q,     COND_NEVER,         A_IDLE);
      5'd18:   ctrl = word(OP_LINK_CUR_NS,   COND_ALWAYS,        A_EMIT);
      5'd19:   ctrl = word(OP_LINK_NS_FIRST, COND_ALWAYS,        A_EMIT);
      5'd20:   ctrl = word(OP_SET_FULL,      COND_ALWAYS,        A_EMIT);
      5'd21:   ctrl = word(OP_NONE,          COND_NOT_RANGE,     A_BAD);
      5'd22:   ctrl = word(OP_NONE,          COND_LP_ZERO,       A_DEL_HEAD);
      5'd23:   ctrl = word(OP_WALK_PRED,     COND_LP_ONE,        A_DEL_VIC);
      5'd24:   ctrl = word(OP_HOP,           COND_K_NOT_ONE,     A_DEL_LOOP);
      5'd25:   ctrl = word(OP_RD_VICTIM,     COND_NEVER,         A_IDLE);
      5'd26:   ctrl = word(OP_UNLINK,        COND_ALWAYS,        A_DEL_PUSH);
      5'd27:   ctrl = word(OP_WALK_POS,      COND_NEVER,         A_IDLE);
      5'd28:   ctrl = word(OP_DEL_HEAD,      COND_NEVER,         A_IDLE);
      5'd29:   ctrl = word(OP_PUSH,          COND_ALWAYS,        A_EMIT);
      5'd31:   ctrl = word(OP_EMIT,          COND_OUT_BUSY,      A_EMIT);
      default: ctrl = word(OP_NONE,          COND_ALWAYS,        A_IDLE);
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:         taken = 1'b0;
      COND_ALWAYS:        taken = 1'b1;
      COND_NO_INPUT:      taken = !in_valid;
      COND_OUT_BUSY:      taken = out_busy;
      COND_CMD_READ:      taken = flags.is_read;
      COND_CMD_INSERT:    taken = flags.is_insert;
      COND_CMD_DELETE:    taken = flags.is_delete;
      COND_NOT_RANGE:     taken = !flags.in_range;
      COND_NOT_INS_RANGE: taken = !flags.ins_range;
      COND_FULL:          taken = flags.full;
      COND_LP_ZERO:       taken = flags.lp_zero;
      COND_LP_ONE:        taken = flags.lp_one;
      COND_K_NOT_ONE:     taken = !flags.k_one;
      default:            taken = 1'b0;
    endcase
    upc_next = taken ? ctrl.jump : upc_t'(upc + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= A_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// File: sv/ille_datapath.sv
// Slot memories, free-slot stack and walk registers of the list engine.
`include "indexed_linked_list_engine_top_defines.svh"
module ille_datapath
  import ille_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  op_t                         op,
  input  logic                        accept,
  input  logic [1:0]                  command,
  input  logic signed [POS_BITS-1:0]  position,
  input  logic signed [DATA_BITS-1:0] value,
  output flags_t                      flags,
  output result_t                     result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > POS_BITS) ? CW : POS_BITS;
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

  logic [1:0]                 cmd_r;
  logic signed [POS_BITS-1:0] pos_r;
  logic [VALUE_BITS-1:0]      val_r;
  logic [AW-1:0]              first;
  logic [AW-1:0]              cur;
  logic [AW-1:0]              ns;
  logic [AW-1:0]              victim;
  logic [CW-1:0]              ec;
  logic [CW-1:0]              fc;
  logic [CW-1:0]              fmark;
  logic [EW-1:0]              k;
  logic [DATA_BITS-1:0]       rd;
  logic [1:0]                 status;

  logic [VALUE_BITS-1:0] value_mem [CAPACITY];
  logic [AW-1:0]         link_mem  [CAPACITY];
  logic [AW-1:0]         free_mem  [CAPACITY];
  logic [VALUE_BITS-1:0] value_q;
  logic [AW-1:0]         link_q;
  logic [AW-1:0]         free_q;

  logic                  pos_neg;
  logic [EW-1:0]         ec_w;
  logic [EW-1:0]         lp;
  logic [CW-1:0]         fc_m1;
  logic                  pop_fresh;
  logic                  push_ok;
  logic [63:0]           val_wide;
  logic [63:0]           value_q_wide;
  logic                  link_re;
  logic [AW-1:0]         link_raddr;
  logic                  link_we;
  logic [AW-1:0]         link_waddr;
  logic [AW-1:0]         link_wdata;

  assign pos_neg      = pos_r[POS_BITS-1];
  assign ec_w         = EW'(ec);
  assign lp           = (cmd_r == CMD_INSERT && pos_neg) ? ec_w : EW'(pos_r[POS_BITS-2:0]);
  assign fc_m1        = fc - 1'b1;
  assign pop_fresh    = fc_m1 < fmark;
  assign push_ok      = fc < CAP_COUNT;
  assign val_wide     = {{DATA_BITS{value[DATA_BITS-1]}}, value};
  assign value_q_wide = 64'(value_q);

  always_comb begin
    flags.is_read   = cmd_r == CMD_READ;
    flags.is_insert = cmd_r == CMD_INSERT;
    flags.is_delete = cmd_r == CMD_DELETE;
    flags.in_range  = !pos_neg && (lp < ec_w);
    flags.ins_range = lp <= ec_w;
    flags.full      = fc == '0;
    flags.lp_zero   = lp == '0;
    flags.lp_one    = lp == EW'(1);
    flags.k_one     = k == EW'(1);
  end

  assign result.read_value  = rd;
  assign result.status      = status;
  assign result.list_length = ec_w[LEN_BITS-1:0];

  always_comb begin
    link_re    = 1'b0;
    link_raddr = first;
    link_we    = 1'b0;
    link_waddr = cur;
    link_wdata = link_q;
    case (op)
      OP_WALK_POS, OP_WALK_PRED: begin
        link_re    = 1'b1;
        link_raddr = first;
      end
      OP_HOP, OP_RD_VICTIM: begin
        link_re    = 1'b1;
        link_raddr = link_q;
      end
      OP_LINK_NS_Q: begin
        link_we    = 1'b1;
        link_waddr = ns;
        link_wdata = link_q;
      end
      OP_LINK_CUR_NS: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = ns;
      end
      OP_LINK_NS_FIRST: begin
        link_we    = 1'b1;
        link_waddr = ns;
        link_wdata = first;
      end
      OP_UNLINK: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = link_q;
      end
      default: begin
        link_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_re) begin
      link_q <= link_mem[link_raddr];
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_RD_VALUE) begin
      value_q <= value_mem[cur];
    end
    if (op == OP_WR_VALUE) begin
      value_mem[ns] <= val_r;
    end
  end

  // Stack entries at or above the low-water mark of the free count hold pushed slots;
  // entries below it were never written, and a pop there takes the entry's own index as the slot.
  always_ff @(posedge clk) begin
    if (op == OP_POP_ADDR) begin
      free_q <= free_mem[fc_m1[AW-1:0]];
    end
    if (op == OP_PUSH && push_ok) begin
      free_mem[fc[AW-1:0]] <= victim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= '0;
      ec    <= '0;
      fc    <= CAP_COUNT;
      fmark <= CAP_COUNT;
    end else begin
      case (op)
        OP_POP: begin
          fc <= fc_m1;
          if (pop_fresh) begin
            fmark <= fc_m1;
          end
        end
        OP_LINK_CUR_NS: begin
          ec <= ec + 1'b1;
        end
        OP_LINK_NS_FIRST: begin
          first <= ns;
          ec    <= ec + 1'b1;
        end
        OP_DEL_HEAD: begin
          first <= link_q;
        end
        OP_PUSH: begin
          if (push_ok) begin
            fc <= fc + 1'b1;
          end
          ec <= ec - 1'b1;
        end
        default: begin
          ec <= ec;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        if (accept) begin
          cmd_r  <= command;
          pos_r  <= position;
          val_r  <= val_wide[VALUE_BITS-1:0];
          rd     <= '0;
          status <= ST_DONE;
        end
      end
      OP_SET_RANGE: begin
        status <= ST_RANGE;
      end
      OP_SET_FULL: begin
        status <= ST_FULL;
      end
      OP_WALK_POS: begin
        cur <= first;
        k   <= lp;
      end
      OP_WALK_PRED: begin
        cur <= first;
        k   <= lp - 1'b1;
      end
      OP_HOP: begin
        cur <= link_q;
        k   <= k - 1'b1;
      end
      OP_TAKE_VALUE: begin
        rd <= value_q_wide[DATA_BITS-1:0];
      end
      OP_POP: begin
        ns <= pop_fresh ? fc_m1[AW-1:0] : free_q;
      end
      OP_RD_VICTIM: begin
        victim <= link_q;
      end
      OP_DEL_HEAD: begin
        victim <= cur;
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  `ILLE_ASSERT_IMP(a_slots_conserved, clk, rst, op == OP_ACCEPT,
                   ({1'b0, fc} + {1'b0, ec}) == (CW+1)'(CAPACITY))
  `ILLE_ASSERT_IMP(a_mark_below_count, clk, rst, 1'b1, fmark <= fc)
  `ILLE_ASSERT_IMP(a_hop_has_count, clk, rst, op == OP_HOP, k != '0)
  `ILLE_ASSERT_NXT(a_length_steps, clk, rst, 1'b1,
                   ec == $past(ec) || ec == $past(ec) + 1'b1 || ec + 1'b1 == $past(ec))

endmodule

// File: sv/indexed_linked_list_engine_top.sv
// Top level of the indexed linked list engine: sequencer, datapath and response register.
//
//   channel  role    beat fields
//   cmd      sink    command, position, value
//   rsp      source  read_value, status, list_length
//
// One command is in flight at a time; the next is taken once its result is registered.
// A read, insert or delete walks the links toward its position, with a negative insert
// position counting as the list length; the walk makes one hop per cycle through the
// link memory. The free-slot stack needs no clearing pass after reset.
// A stalled response holds the sequencer at its emit step until the beat is taken.
module indexed_linked_list_engine_top
  import ille_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  ille_cmd_if.sink   cmd,
  ille_rsp_if.source rsp
);

  ctrl_t   ctrl;
  flags_t  flags;
  result_t result;
  result_t rsp_data;
  logic    rsp_valid;
  logic    accept;
  logic    out_busy;
  logic    emit;

  assign cmd.ready = (ctrl.op == OP_ACCEPT) && !rst;
  assign accept    = cmd.valid && cmd.ready;
  assign out_busy  = rsp_valid && !rsp.ready;
  assign emit      = (ctrl.op == OP_EMIT) && !out_busy;

  ille_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .out_busy (out_busy),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  ille_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .op       (ctrl.op),
    .accept   (accept),
    .command  (cmd.command),
    .position (cmd.position),
    .value    (cmd.value),
    .flags    (flags),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.read_value  = rsp_data.read_value;
  assign rsp.status      = rsp_data.status;
  assign rsp.list_length = rsp_data.list_length;

endmodule

// File: tb/ille_list_checker.sv
// Checker that predicts every response of the indexed linked list engine and compares it.
module ille_list_checker
  import ille_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic clk,
  input  logic rst,
  ille_cmd_if  cmd,
  ille_rsp_if  rsp,
  output int   mismatches,
  output int   outstanding,
  output int   checked
);

  logic [DATA_BITS-1:0] list_values[$];
  result_t              awaited[$];

  function automatic result_t apply_command(input logic [1:0] op,
                                            input logic signed [POS_BITS-1:0] pos,
                                            input logic [DATA_BITS-1:0] val);
    result_t res;
    int      len;
    int      idx;
    res = '0;
    len = list_values.size();
    idx = pos;
    case (op)
      CMD_READ: begin
        if (idx >= 0 && idx < len) res.read_value = list_values[idx];
        else res.status = ST_RANGE;
      end
      CMD_INSERT: begin
        if (idx < 0) idx = len;
        if (idx > len) res.status = ST_RANGE;
        else if (len >= SLOTS) res.status = ST_FULL;
        else list_values.insert(idx, val);
      end
      CMD_DELETE: begin
        if (idx >= 0 && idx < len) list_values.delete(idx);
        else res.status = ST_RANGE;
      end
      default: begin
        res.status = ST_RANGE;
      end
    endcase
    res.list_length = list_values.size();
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      list_values.delete();
      awaited.delete();
      mismatches = 0;
      outstanding = 0;
      checked = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.read_value = rsp.read_value;
        got.status = rsp.status;
        got.list_length = rsp.list_length;
        if (awaited.size() == 0) begin
          note_mismatch($sformatf("response beat with nothing awaited: value %h status %0d length %0d",
                                  got.read_value, got.status, got.list_length));
        end else begin
          want = awaited.pop_front();
          if (got.read_value !== want.read_value || got.status !== want.status ||
              got.list_length !== want.list_length) begin
            note_mismatch($sformatf({"response %0d differs: expected value %h status %0d ",
                                     "length %0d, got value %h status %0d length %0d"},
                                    checked, want.read_value, want.status, want.list_length,
                                    got.read_value, got.status, got.list_length));
          end
        end
        checked++;
      end
      if (cmd.valid && cmd.ready) begin
        awaited.push_back(apply_command(cmd.command, cmd.position, cmd.value));
      end
      outstanding = awaited.size();
    end
  end

endmodule

// File: tb/tb_indexed_linked_list_engine_top.sv
// Testbench top of the indexed linked list engine: clock, reset, stimulus and verdict.
module tb_indexed_linked_list_engine_top;
  import ille_pkg::*;

  localparam int         CLK_PERIOD     = 8;
  localparam int         STORE_SLOTS    = 256;
  localparam int         COMMAND_TARGET = 750;
  localparam int         DIRECTED_COUNT = 24;
  localparam int         DRAIN_CYCLES   = 300;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;

  typedef enum logic [1:0] {FILLING, DRAINING, MIXING} phase_t;

  logic clk;
  logic rst;
  logic calm;
  int   mismatches;
  int   outstanding;
  int   checked;
  int   sent;
  int   peak_len;
  int   full_refusals;
  int   observed_len;
  int   rsp_hold;

  ille_cmd_if cmd_ch ();
  ille_rsp_if rsp_ch ();

  indexed_linked_list_engine_top #(
    .CAPACITY  (STORE_SLOTS),
    .VALUE_BITS(DATA_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  ille_list_checker #(
    .SLOTS(STORE_SLOTS)
  ) list_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 2_000_000);
    $display("Mismatches found");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold <= 0;
      calm <= 1'b0;
      observed_len <= 0;
      peak_len <= 0;
      full_refusals <= 0;
    end else begin
      if ($urandom_range(0, 399) == 0) calm <= !calm;
      if (rsp_hold > 0) begin
        rsp_hold <= rsp_hold - 1;
        rsp_ch.ready <= 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b0;
        rsp_hold <= pick_gap() - 1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        observed_len <= rsp_ch.list_length;
        if (rsp_ch.list_length > peak_len) peak_len <= rsp_ch.list_length;
        if (rsp_ch.status == ST_FULL) full_refusals <= full_refusals + 1;
      end
    end
  end

  task automatic send_command(input logic [1:0] op, input logic signed [POS_BITS-1:0] pos,
                              input logic [DATA_BITS-1:0] val);
    int gap;
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= op;
    cmd_ch.position <= pos;
    cmd_ch.value <= val;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sent++;
    gap = (calm || $urandom_range(0, 2) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    phase_t                      phase;
    int                          useful;
    int                          full_tries;
    int                          c;
    int                          hi;
    logic [1:0]                  op;
    logic signed [POS_BITS-1:0]  pos;
    sent = 0;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.command <= CMD_READ;
    cmd_ch.position <= '0;
    cmd_ch.value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_command(CMD_READ, 9'sd0, 32'h0);
    send_command(CMD_DELETE, 9'sd0, 32'h0);
    send_command(CMD_INSERT, 9'sd1, 32'h1234_5678);
    send_command(CMD_INSERT, 9'sd0, 32'h7FFF_FFFF);
    send_command(CMD_INSERT, -9'sd1, 32'h8000_0000);
    send_command(CMD_INSERT, -9'sd256, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 9'sd1, 32'h0000_0000);
    send_command(CMD_INSERT, 9'sd4, 32'h5A5A_A5A5);
    send_command(CMD_INSERT, 9'sd255, 32'h0F0F_F0F0);
    for (int i = 0; i < 5; i++) send_command(CMD_READ, 9'(i), 32'hFFFF_FFFF);
    send_command(CMD_READ, 9'sd5, 32'h0);
    send_command(CMD_READ, -9'sd1, 32'h0);
    send_command(CMD_READ, -9'sd256, 32'h0);
    send_command(CMD_READ, 9'sd255, 32'h0);
    send_command(CMD_UNUSED, 9'sd0, 32'hDEAD_BEEF);
    send_command(CMD_DELETE, 9'sd2, 32'h0);
    send_command(CMD_DELETE, 9'sd255, 32'h0);
    send_command(CMD_DELETE, -9'sd1, 32'h0);
    send_command(CMD_DELETE, 9'sd0, 32'h0);
    send_command(CMD_READ, 9'sd0, 32'h0);

    phase = FILLING;
    useful = 0;
    full_tries = 0;
    while (useful < COMMAND_TARGET - DIRECTED_COUNT) begin
      if ($urandom_range(0, 99) < 8) begin
        send_command(2'($urandom_range(0, 3)), 9'($urandom), pick_value());
      end else begin
        c = $urandom_range(0, 99);
        case (phase)
          FILLING: op = (c < 85) ? CMD_INSERT : (c < 93) ? CMD_READ : CMD_DELETE;
          DRAINING: op = (c < 85) ? CMD_DELETE : (c < 93) ? CMD_READ : CMD_INSERT;
          default: op = (c < 40) ? CMD_INSERT : (c < 80) ? CMD_DELETE : CMD_READ;
        endcase
        if (op == CMD_INSERT) begin
          hi = (observed_len > STORE_SLOTS - 1) ? STORE_SLOTS - 1 : observed_len;
          if ($urandom_range(0, 6) == 0) pos = 9'(-int'($urandom_range(1, 256)));
          else pos = 9'($urandom_range(0, hi));
        end else begin
          hi = (observed_len == 0) ? 0 : observed_len - 1;
          pos = 9'($urandom_range(0, hi));
        end
        send_command(op, pos, pick_value());
        useful++;
        if (phase == FILLING && observed_len >= STORE_SLOTS) begin
          full_tries++;
          if (full_tries >= 8) phase = DRAINING;
        end else if (phase == DRAINING && observed_len == 0) begin
          phase = MIXING;
        end
      end
    end

    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d commands and checked %0d responses; the list reached %0d entries.",
             sent, checked, peak_len);
    $display("Inserts refused by a full store: %0d.", full_refusals);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: indexed_linked_list_engine_top.f
+incdir+sv
sv/ille_pkg.sv
sv/ille_channels.sv
sv/ille_sequencer.sv
sv/ille_datapath.sv
sv/indexed_linked_list_engine_top.sv
tb/ille_list_checker.sv
tb/tb_indexed_linked_list_engine_top.sv
